// ----- hw/rtl/lvr3d_pkg.sv -----
// lvr3d_pkg: shared constants and types for the 3D line voxel rasteriser.
// No dependencies. Used by the channel interfaces and the core.
`timescale 1ns / 1ps

package lvr3d_pkg;

   localparam int COORD_BITS_DEF = 4;
   localparam int VALUE_BITS     = 32;
   localparam int NUM_AXES       = 3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SETUP,
      ST_RUN
   } lvr_state_type;

endpackage

// ----- hw/rtl/lvr3d_if.sv -----
// lvr3d_req_if / lvr3d_rsp_if: valid/ready channels carrying line requests
// and rasterised voxels. Depends on lvr3d_pkg.
`timescale 1ns / 1ps

interface lvr3d_req_if #(
   parameter int COORD_BITS = lvr3d_pkg::COORD_BITS_DEF
);
   logic                             valid;
   logic                             ready;
   logic [lvr3d_pkg::VALUE_BITS-1:0] value;
   logic [COORD_BITS-1:0]            x_start;
   logic [COORD_BITS-1:0]            y_start;
   logic [COORD_BITS-1:0]            z_start;
   logic [COORD_BITS-1:0]            x_end;
   logic [COORD_BITS-1:0]            y_end;
   logic [COORD_BITS-1:0]            z_end;

   modport source (
      output valid, value, x_start, y_start, z_start, x_end, y_end, z_end,
      input  ready
   );
   modport sink (
      input  valid, value, x_start, y_start, z_start, x_end, y_end, z_end,
      output ready
   );
endinterface

interface lvr3d_rsp_if #(
   parameter int COORD_BITS = lvr3d_pkg::COORD_BITS_DEF
);
   logic                             valid;
   logic                             ready;
   logic [COORD_BITS-1:0]            voxel_x;
   logic [COORD_BITS-1:0]            voxel_y;
   logic [COORD_BITS-1:0]            voxel_z;
   logic [lvr3d_pkg::VALUE_BITS-1:0] voxel_value;
   logic                             last;

   modport source (
      output valid, voxel_x, voxel_y, voxel_z, voxel_value, last,
      input  ready
   );
   modport sink (
      input  valid, voxel_x, voxel_y, voxel_z, voxel_value, last,
      output ready
   );
endinterface

// ----- hw/rtl/line_voxel_rasterizer_3d_core.sv -----
// line_voxel_rasterizer_3d_core: 3D Bresenham line rasteriser.
// Steps per request: accept in idle, setup, then run emits the voxels.
// Throughput: one voxel per cycle while rsp is ready; a request with dominant
// length L yields L + 1 voxels, and a new request is taken only in idle.
// The per-axis step/error lanes are the limit: one voxel per update.
// Reset (synchronous, active high) returns to idle and drops rsp valid.
`timescale 1ns / 1ps

module line_voxel_rasterizer_3d_core #(
   parameter int COORD_BITS = lvr3d_pkg::COORD_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   lvr3d_req_if.sink   req_chan,
   lvr3d_rsp_if.source rsp_chan
);

   localparam int NA = lvr3d_pkg::NUM_AXES;
   localparam int VB = lvr3d_pkg::VALUE_BITS;
   localparam int EB = COORD_BITS + 3;   // error term, signed

   lvr3d_pkg::lvr_state_type state_ff, state_in;

   logic [VB-1:0]                value_ff, value_in;
   logic [COORD_BITS-1:0]        pos_ff [NA];
   logic [COORD_BITS-1:0]        pos_in [NA];
   logic [COORD_BITS-1:0]        end_ff [NA];
   logic [COORD_BITS-1:0]        end_in [NA];
   logic [COORD_BITS-1:0]        len_ff [NA];
   logic [COORD_BITS-1:0]        len_in [NA];
   logic [NA-1:0]                dir_ff, dir_in;   // 1: step downwards
   logic [NA-1:0]                dom_ff, dom_in;   // one-hot dominant axis
   logic [COORD_BITS-1:0]        dom_len_ff, dom_len_in;
   logic [COORD_BITS-1:0]        count_ff, count_in;
   logic signed [EB-1:0]         err_ff [NA];
   logic signed [EB-1:0]         err_in [NA];

   logic                         out_valid_ff, out_valid_in;
   logic [COORD_BITS-1:0]        out_pos_ff [NA];
   logic [COORD_BITS-1:0]        out_pos_in [NA];
   logic [VB-1:0]                out_value_ff, out_value_in;
   logic                         out_last_ff, out_last_in;

   logic                         req_take;
   logic                         out_free;
   logic [COORD_BITS-1:0]        len_c [NA];
   logic [NA-1:0]                dom_c;
   logic [COORD_BITS-1:0]        dom_len_c;
   logic signed [EB-1:0]         two_dom;

   assign req_chan.ready = (state_ff == lvr3d_pkg::ST_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign out_free       = !out_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.voxel_x     = out_pos_ff[0];
   assign rsp_chan.voxel_y     = out_pos_ff[1];
   assign rsp_chan.voxel_z     = out_pos_ff[2];
   assign rsp_chan.voxel_value = out_value_ff;
   assign rsp_chan.last        = out_last_ff;

   assign two_dom = signed'({2'b00, dom_len_ff, 1'b0});

   // axis lengths and dominant-axis pick; ties go x, then y, then z
   always_comb begin
      for (int i = 0; i < NA; i++) begin
         len_c[i] = (end_ff[i] < pos_ff[i]) ? pos_ff[i] - end_ff[i]
                                              : end_ff[i] - pos_ff[i];
      end
      if (len_c[0] >= len_c[1] && len_c[0] >= len_c[2]) begin
         dom_c = 3'b001;
      end else if (len_c[1] >= len_c[2]) begin
         dom_c = 3'b010;
      end else begin
         dom_c = 3'b100;
      end
      dom_len_c = dom_c[0] ? len_c[0] : (dom_c[1] ? len_c[1] : len_c[2]);
   end

   always_comb begin
      state_in     = state_ff;
      value_in     = value_ff;
      pos_in       = pos_ff;
      end_in       = end_ff;
      len_in       = len_ff;
      dir_in       = dir_ff;
      dom_in       = dom_ff;
      dom_len_in   = dom_len_ff;
      count_in     = count_ff;
      err_in       = err_ff;
      out_pos_in   = out_pos_ff;
      out_value_in = out_value_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;

      unique case (state_ff)
         lvr3d_pkg::ST_IDLE: begin
            if (req_take) begin
               value_in  = req_chan.value;
               pos_in[0] = req_chan.x_start;
               pos_in[1] = req_chan.y_start;
               pos_in[2] = req_chan.z_start;
               end_in[0] = req_chan.x_end;
               end_in[1] = req_chan.y_end;
               end_in[2] = req_chan.z_end;
               state_in  = lvr3d_pkg::ST_SETUP;
            end
         end
         lvr3d_pkg::ST_SETUP: begin
            for (int i = 0; i < NA; i++) begin
               len_in[i] = len_c[i];
               dir_in[i] = end_ff[i] < pos_ff[i];
               err_in[i] = signed'({2'b00, len_c[i], 1'b0})
                         - signed'({3'b000, dom_len_c});
            end
            dom_in     = dom_c;
            dom_len_in = dom_len_c;
            count_in   = dom_len_c;
            state_in   = lvr3d_pkg::ST_RUN;
         end
         lvr3d_pkg::ST_RUN: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_pos_in   = pos_ff;
               out_value_in = value_ff;
               out_last_in  = (count_ff == '0);
               if (count_ff == '0) begin
                  state_in = lvr3d_pkg::ST_IDLE;
               end else begin
                  count_in = count_ff - COORD_BITS'(1);
                  // minor axes step on a strictly positive error
                  for (int i = 0; i < NA; i++) begin
                     if (dom_ff[i] || err_ff[i] > 0) begin
                        pos_in[i] = dir_ff[i] ? pos_ff[i] - COORD_BITS'(1)
                                              : pos_ff[i] + COORD_BITS'(1);
                     end
                     err_in[i] = err_ff[i] + signed'({2'b00, len_ff[i], 1'b0})
                               - ((!dom_ff[i] && err_ff[i] > 0) ? two_dom
                                                                : EB'(0));
                  end
               end
            end
         end
         default: begin
            state_in = lvr3d_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lvr3d_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      value_ff     <= value_in;
      pos_ff       <= pos_in;
      end_ff       <= end_in;
      len_ff       <= len_in;
      dir_ff       <= dir_in;
      dom_ff       <= dom_in;
      dom_len_ff   <= dom_len_in;
      count_ff     <= count_in;
      err_ff       <= err_in;
      out_pos_ff   <= out_pos_in;
      out_value_ff <= out_value_in;
      out_last_ff  <= out_last_in;
   end

endmodule
